// ----- sv/modbus_rtu_read_master_framer_core_defines.svh -----
// Assertion macros shared by the framer RTL.
`ifndef MODBUS_RTU_READ_MASTER_FRAMER_CORE_DEFINES_SVH
`define MODBUS_RTU_READ_MASTER_FRAMER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// Clocked check, quiet while reset is held
`define MRF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked check that also holds during reset
`define MRF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MRF_ASSERT(lbl, clk, rst_n, prop, msg)
`define MRF_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ----- sv/mrf_pkg.sv -----
`default_nettype none

package mrf_pkg;

    // Input item kinds
    localparam logic IN_REQUEST   = 1'b0;
    localparam logic IN_RESP_BYTE = 1'b1;

    // Result kinds
    localparam logic [1:0] KIND_TX     = 2'd0;
    localparam logic [1:0] KIND_DATA   = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    // Response status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_SHORT    = 2'd1;
    localparam logic [1:0] ST_MISMATCH = 2'd2;
    localparam logic [1:0] ST_COUNT    = 2'd3;

    // CRC-16/MODBUS
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Shortest valid response, and width used for position compares
    localparam int MIN_RESPONSE = 7;
    localparam int CMP_W        = 10;
    localparam int DATA_OFFSET  = 3;

    // Command queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);

    typedef struct packed {
        logic        is_req;
        logic [7:0]  addr;
        logic [7:0]  func;
        logic [15:0] start_reg;
        logic [15:0] reg_count;
        logic [7:0]  data;
        logic        has_data;
        logic        has_status;
        logic [1:0]  status;
    } t_cmd;

    // One byte through the reflected CRC, bit at a time
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- sv/mrf_if.sv -----
`default_nettype none

// Request channel
interface mrf_in_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  slave_address;
    logic [7:0]  function_code;
    logic [15:0] start_register;
    logic [15:0] register_count;
    logic [7:0]  rx_byte;
    logic        rx_last;

    modport source (
        output valid, kind, slave_address, function_code, start_register,
               register_count, rx_byte, rx_last,
        input  ready
    );
    modport sink (
        input  valid, kind, slave_address, function_code, start_register,
               register_count, rx_byte, rx_last,
        output ready
    );
endinterface

// Result channel
interface mrf_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] out_kind;
    logic [7:0] out_byte;
    logic       run_last;
    logic [1:0] resp_status;

    modport source (
        output valid, out_kind, out_byte, run_last, resp_status,
        input  ready
    );
    modport sink (
        input  valid, out_kind, out_byte, run_last, resp_status,
        output ready
    );
endinterface

`default_nettype wire

// ----- sv/mrf_front.sv -----
`default_nettype none

module mrf_front #(
    parameter int RX_BUFFER_BYTES = 64
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    mrf_in_if.sink      i_req,
    input  wire logic   i_full,
    output logic        o_push,
    output mrf_pkg::t_cmd o_cmd
);
    import mrf_pkg::*;

    localparam int PW = $clog2(RX_BUFFER_BYTES + 1);

    logic [7:0]    r_exp_addr, n_exp_addr;
    logic [7:0]    r_exp_func, n_exp_func;
    logic [PW-1:0] r_rx_pos, n_rx_pos;
    logic [7:0]    r_data_count, n_data_count;
    logic          r_mismatch, n_mismatch;

    assign i_req.ready = !i_full;

    // Classify the request and update the response tracking state
    always_comb begin
        logic [CMP_W-1:0] data_end;
        data_end     = CMP_W'(r_data_count) + CMP_W'(DATA_OFFSET);
        n_exp_addr   = r_exp_addr;
        n_exp_func   = r_exp_func;
        n_rx_pos     = r_rx_pos;
        n_data_count = r_data_count;
        n_mismatch   = r_mismatch;
        o_cmd        = '0;
        o_push       = 1'b0;
        if (i_req.valid && i_req.ready) begin
            if (i_req.kind == IN_REQUEST) begin
                n_exp_addr      = i_req.slave_address;
                n_exp_func      = i_req.function_code;
                n_rx_pos        = '0;
                n_data_count    = '0;
                n_mismatch      = 1'b0;
                o_cmd.is_req    = 1'b1;
                o_cmd.addr      = i_req.slave_address;
                o_cmd.func      = i_req.function_code;
                o_cmd.start_reg = i_req.start_register;
                o_cmd.reg_count = i_req.register_count;
                o_push          = 1'b1;
            end else begin
                o_cmd.data = i_req.rx_byte;
                if (r_rx_pos < PW'(RX_BUFFER_BYTES)) begin
                    n_rx_pos = r_rx_pos + PW'(1);
                    if (r_rx_pos == PW'(0)) begin
                        if (i_req.rx_byte != r_exp_addr) n_mismatch = 1'b1;
                    end else if (r_rx_pos == PW'(1)) begin
                        if (i_req.rx_byte != r_exp_func) n_mismatch = 1'b1;
                    end else if (r_rx_pos == PW'(2)) begin
                        n_data_count = i_req.rx_byte;
                    end else if (CMP_W'(r_rx_pos) < data_end) begin
                        o_cmd.has_data = 1'b1;
                    end
                end
                // Last byte: judge the response, then start over
                if (i_req.rx_last) begin
                    o_cmd.has_status = 1'b1;
                    if (CMP_W'(n_rx_pos) < CMP_W'(MIN_RESPONSE)) begin
                        o_cmd.status = ST_SHORT;
                    end else if (n_mismatch) begin
                        o_cmd.status = ST_MISMATCH;
                    end else if (CMP_W'(n_data_count) + CMP_W'(DATA_OFFSET)
                                 > CMP_W'(n_rx_pos)) begin
                        o_cmd.status = ST_COUNT;
                    end else begin
                        o_cmd.status = ST_OK;
                    end
                    n_rx_pos     = '0;
                    n_data_count = '0;
                    n_mismatch   = 1'b0;
                end
                o_push = o_cmd.has_data || o_cmd.has_status;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_addr   <= '0;
            r_exp_func   <= '0;
            r_rx_pos     <= '0;
            r_data_count <= '0;
            r_mismatch   <= 1'b0;
        end else begin
            r_exp_addr   <= n_exp_addr;
            r_exp_func   <= n_exp_func;
            r_rx_pos     <= n_rx_pos;
            r_data_count <= n_data_count;
            r_mismatch   <= n_mismatch;
        end
    end

endmodule

`default_nettype wire

// ----- sv/mrf_cmd_queue.sv -----
`default_nettype none

module mrf_cmd_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire mrf_pkg::t_cmd i_data,
    output logic               o_full,
    input  wire logic          i_pop,
    output logic               o_empty,
    output mrf_pkg::t_cmd      o_head
);
    import mrf_pkg::*;

    t_cmd                 r_slot [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [Q_PTR_W:0]     r_count;

    assign o_full  = (r_count == (Q_PTR_W + 1)'(Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_slot[r_rd_ptr];

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_slot[r_wr_ptr] <= i_data;
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + Q_PTR_W'(1);
            if (i_pop)  r_rd_ptr <= r_rd_ptr + Q_PTR_W'(1);
            if (i_push && !i_pop)      r_count <= r_count + (Q_PTR_W + 1)'(1);
            else if (!i_push && i_pop) r_count <= r_count - (Q_PTR_W + 1)'(1);
        end
    end

endmodule

`default_nettype wire

// ----- sv/mrf_back.sv -----
`default_nettype none

module mrf_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire mrf_pkg::t_cmd i_head,
    input  wire logic          i_empty,
    output logic               o_pop,
    mrf_out_if.source          o_rsp
);
    import mrf_pkg::*;

    // Frame byte positions
    localparam logic [2:0] STEP_ADDR   = 3'd0;
    localparam logic [2:0] STEP_FUNC   = 3'd1;
    localparam logic [2:0] STEP_REG_HI = 3'd2;
    localparam logic [2:0] STEP_REG_LO = 3'd3;
    localparam logic [2:0] STEP_CNT_HI = 3'd4;
    localparam logic [2:0] STEP_CNT_LO = 3'd5;
    localparam logic [2:0] STEP_CRC_LO = 3'd6;
    localparam logic [2:0] STEP_CRC_HI = 3'd7;

    t_cmd        r_cur;
    logic        r_active;
    logic [2:0]  r_step;
    logic [15:0] r_crc;

    logic        r_out_valid;
    logic [1:0]  r_out_kind;
    logic [7:0]  r_out_byte;
    logic        r_out_last;
    logic [1:0]  r_out_status;

    logic        w_can_emit, w_fin;
    logic [1:0]  w_kind;
    logic [7:0]  w_byte;
    logic        w_run_last, w_last_cmd;
    logic [1:0]  w_status;
    logic [15:0] w_crc_next;

    assign w_can_emit = r_active && (!r_out_valid || o_rsp.ready);
    assign w_fin      = w_can_emit && w_last_cmd;
    assign o_pop      = !i_empty && (!r_active || w_fin);

    // Result for the current step of the command
    always_comb begin
        w_kind     = KIND_STATUS;
        w_byte     = 8'h00;
        w_run_last = 1'b1;
        w_last_cmd = 1'b1;
        w_status   = ST_OK;
        if (r_cur.is_req) begin
            w_kind     = KIND_TX;
            w_run_last = (r_step == STEP_CRC_HI);
            w_last_cmd = (r_step == STEP_CRC_HI);
            case (r_step)
                STEP_ADDR:   w_byte = r_cur.addr;
                STEP_FUNC:   w_byte = r_cur.func;
                STEP_REG_HI: w_byte = r_cur.start_reg[15:8];
                STEP_REG_LO: w_byte = r_cur.start_reg[7:0];
                STEP_CNT_HI: w_byte = r_cur.reg_count[15:8];
                STEP_CNT_LO: w_byte = r_cur.reg_count[7:0];
                STEP_CRC_LO: w_byte = r_crc[7:0];
                default:     w_byte = r_crc[15:8];
            endcase
        end else if (r_cur.has_data && (r_step == STEP_ADDR)) begin
            w_kind     = KIND_DATA;
            w_byte     = r_cur.data;
            w_run_last = !r_cur.has_status;
            w_last_cmd = !r_cur.has_status;
        end else begin
            w_status = r_cur.status;
        end
    end

    // CRC runs over the six header bytes as they go out
    assign w_crc_next = crc16_byte((r_step == STEP_ADDR) ? CRC_INIT : r_crc, w_byte);

    // Sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_active <= 1'b1;
                r_step   <= '0;
            end else if (w_fin) begin
                r_active <= 1'b0;
            end else if (w_can_emit) begin
                r_step <= r_step + 3'd1;
            end
            if (w_can_emit)        r_out_valid <= 1'b1;
            else if (o_rsp.ready)  r_out_valid <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (o_pop) r_cur <= i_head;
        if (w_can_emit && r_cur.is_req && (r_step <= STEP_CNT_LO)) r_crc <= w_crc_next;
        if (w_can_emit) begin
            r_out_kind   <= w_kind;
            r_out_byte   <= w_byte;
            r_out_last   <= w_run_last;
            r_out_status <= w_status;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.out_kind    = r_out_kind;
    assign o_rsp.out_byte    = r_out_byte;
    assign o_rsp.run_last    = r_out_last;
    assign o_rsp.resp_status = r_out_status;

endmodule

`default_nettype wire

// ----- sv/modbus_rtu_read_master_framer_core.sv -----
// Channel   Modport   Moves
// i_req     sink      read request or one received response byte
// o_rsp     source    frame byte, response data byte or response status
//
// A read request yields eight frame bytes from the back-end byte sequencer, one per
// cycle while o_rsp is not stalled; a response byte yields zero, one or two results.
// The front end takes one item per cycle while the 4-entry command queue has room.
// Reset is synchronous and active low; it clears the response tracking,
// the queue and the output register. No clearing pass follows reset.
// A stalled output holds the back end only; the front keeps filling the queue.
`default_nettype none
`include "modbus_rtu_read_master_framer_core_defines.svh"

module modbus_rtu_read_master_framer_core #(
    parameter int RX_BUFFER_BYTES = 64
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    mrf_in_if.sink    i_req,
    mrf_out_if.source o_rsp
);
    import mrf_pkg::*;

    t_cmd w_cmd, w_head;
    logic w_push, w_full, w_pop, w_empty;

    // Accept and classify
    mrf_front #(
        .RX_BUFFER_BYTES(RX_BUFFER_BYTES)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_cmd   (w_cmd)
    );

    // Decoupling queue
    mrf_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_cmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_head  (w_head)
    );

    // Emit results
    mrf_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .i_empty (w_empty),
        .o_pop   (w_pop),
        .o_rsp   (o_rsp)
    );

    `MRF_ASSERT(a_no_overflow, i_clk, i_rst_n, w_push |-> !w_full, "queue push while full")
    `MRF_ASSERT(a_no_underflow, i_clk, i_rst_n, w_pop |-> !w_empty, "queue pop while empty")
    `MRF_ASSERT(a_status_last, i_clk, i_rst_n, (o_rsp.valid && o_rsp.out_kind == KIND_STATUS) |-> o_rsp.run_last, "status result not marked last")
    `MRF_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !o_rsp.valid, "output valid after reset")

endmodule

`default_nettype wire
